@@ sv/bole_pkg.sv @@
package bole_pkg;

   // Request codes carried in the low bits of the request data.
   localparam logic [2:0] REQ_INS_FRONT = 3'd0;
   localparam logic [2:0] REQ_INS_BACK  = 3'd1;
   localparam logic [2:0] REQ_INS_AFTER = 3'd2;
   localparam logic [2:0] REQ_REM_BACK  = 3'd3;
   localparam logic [2:0] REQ_REM_FRONT = 3'd4;
   localparam logic [2:0] REQ_REM_VALUE = 3'd5;

   // Status codes returned with every response.
   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_EMPTY    = 3'd1;
   localparam logic [2:0] STAT_BEYOND   = 3'd2;
   localparam logic [2:0] STAT_NOTFOUND = 3'd3;
   localparam logic [2:0] STAT_FULL     = 3'd4;

   // Sequencer states.
   typedef enum logic [2:0] {
      FSM_IDLE  = 3'b001,
      FSM_MATCH = 3'b010,
      FSM_APPLY = 3'b100
   } state_type;

   // Per-cell control issued by the sequencer.
   typedef struct packed {
      logic load;              // take the new value
      logic from_left;         // take the left neighbor's value (insert shift)
      logic from_right;        // take the right neighbor's value (remove shift)
      logic from_right_found;  // take the right value at or after the first match
      logic capture;           // register the compare result
   } cell_ctrl_type;

endpackage

@@ sv/bole_cell.sv @@
module bole_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                    clock,
   input  bole_pkg::cell_ctrl_type ctrl,
   input  logic                    valid,
   input  logic [DATA_WIDTH-1:0]   key,
   input  logic [DATA_WIDTH-1:0]   new_value,
   input  logic [DATA_WIDTH-1:0]   left_value,
   input  logic [DATA_WIDTH-1:0]   right_value,
   input  logic                    found_in,
   output logic [DATA_WIDTH-1:0]   value,
   output logic                    found_out
);

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;
   logic                  match_ff;
   logic                  match_in;

   // A match here or in any cell to the left marks this cell for a left shift.
   assign found_out = found_in | match_ff;
   assign value     = value_ff;

   // Select the next stored value from the neighbors or the new item.
   always_comb begin
      if (ctrl.load) begin
         value_in = new_value;
      end else if (ctrl.from_left) begin
         value_in = left_value;
      end else if (ctrl.from_right || (ctrl.from_right_found && found_out)) begin
         value_in = right_value;
      end else begin
         value_in = value_ff;
      end
   end

   // Compare only occupied entries against the search key.
   assign match_in = ctrl.capture ? (valid && (value_ff == key)) : match_ff;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

endmodule

@@ sv/bounded_ordered_list_engine.sv @@
// Channel  Direction  tdata fields (lowest bit first)
// req      in         req_type[2:0], data_value[34:3], position[39:35]
// rsp      out        status[2:0], list_length[7:3]
//
// Each request passes through the steps accept, compare in every cell, then shift
// the cell chain and load the response register. The per-cell compare and the
// found chain through the cells set this split into steps.
// Reset clears the entry count, the sequencer and the response valid.
// The next request is taken once the sequencer is back in idle; a stalled
// response holds the apply step until the previous response is taken.
module bounded_ordered_list_engine #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // req_type[2:0], data_value[34:3], position[39:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // status[2:0], list_length[7:3]
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 5) ? CW : 5;

   bole_pkg::state_type state_ff, state_in;

   logic [2:0]            type_ff;
   logic [DATA_WIDTH-1:0] key_ff;
   logic [4:0]            pos_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_status_ff, status_in;
   logic [4:0]            rsp_length_ff;

   logic req_fire;
   logic apply_go;
   logic do_insert;
   logic do_remove_idx;
   logic do_remove_found;
   logic [CW-1:0] idx;
   logic [PW-1:0] pos_eff;
   logic [PW-1:0] count_ext;
   logic [PW-1:0] count_in_ext;

   bole_pkg::cell_ctrl_type ctrl [CAPACITY];
   logic [DATA_WIDTH-1:0]   cell_value [CAPACITY];
   logic [CAPACITY:0]       found;

   assign req_tready = (state_ff == bole_pkg::FSM_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign apply_go   = (state_ff == bole_pkg::FSM_APPLY) && (!rsp_valid_ff || rsp_tready);

   // Sequencer: idle, compare, apply.
   always_comb begin
      case (state_ff)
         bole_pkg::FSM_IDLE:  state_in = req_fire ? bole_pkg::FSM_MATCH : bole_pkg::FSM_IDLE;
         bole_pkg::FSM_MATCH: state_in = bole_pkg::FSM_APPLY;
         bole_pkg::FSM_APPLY: state_in = apply_go ? bole_pkg::FSM_IDLE : bole_pkg::FSM_APPLY;
         default:             state_in = bole_pkg::FSM_IDLE;
      endcase
   end

   // Request register; the value is sign-extended or cut to the entry width.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff <= req_tdata[2:0];
         key_ff  <= DATA_WIDTH'($signed(req_tdata[34:3]));
         pos_ff  <= req_tdata[39:35];
      end
   end

   assign count_ext = PW'(count_ff);
   assign pos_eff   = (pos_ff == 5'd0) ? PW'(1) : PW'(pos_ff);

   // Decode the operation, its status and the new length.
   always_comb begin
      do_insert       = 1'b0;
      do_remove_idx   = 1'b0;
      do_remove_found = 1'b0;
      idx             = '0;
      status_in       = bole_pkg::STAT_OK;
      count_in        = count_ff;
      if (type_ff inside {bole_pkg::REQ_INS_FRONT, bole_pkg::REQ_INS_BACK,
                          bole_pkg::REQ_INS_AFTER}) begin
         if (count_ff == CW'(CAPACITY)) begin
            status_in = bole_pkg::STAT_FULL;
         end else if (type_ff == bole_pkg::REQ_INS_FRONT) begin
            do_insert = 1'b1;
         end else if (type_ff == bole_pkg::REQ_INS_BACK) begin
            do_insert = 1'b1;
            idx       = count_ff;
         end else if (count_ff == '0 || pos_eff > count_ext) begin
            status_in = bole_pkg::STAT_BEYOND;
         end else begin
            do_insert = 1'b1;
            idx       = pos_eff[CW-1:0];
         end
         if (do_insert) begin
            count_in = count_ff + CW'(1);
         end
      end else if (type_ff inside {bole_pkg::REQ_REM_BACK, bole_pkg::REQ_REM_FRONT,
                                   bole_pkg::REQ_REM_VALUE}) begin
         if (count_ff == '0) begin
            status_in = bole_pkg::STAT_EMPTY;
         end else if (type_ff == bole_pkg::REQ_REM_BACK) begin
            count_in = count_ff - CW'(1);
         end else if (type_ff == bole_pkg::REQ_REM_FRONT) begin
            do_remove_idx = 1'b1;
            count_in      = count_ff - CW'(1);
         end else if (found[CAPACITY]) begin
            do_remove_found = 1'b1;
            count_in        = count_ff - CW'(1);
         end else begin
            status_in = bole_pkg::STAT_NOTFOUND;
         end
      end
   end

   assign count_in_ext = PW'(count_in);

   // Chain of cells; each neighbor pair exchanges values for shifts.
   assign found[0] = 1'b0;

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      assign ctrl[k].load             = apply_go && do_insert && (idx == CW'(k));
      assign ctrl[k].from_left        = apply_go && do_insert && (CW'(k) > idx);
      assign ctrl[k].from_right       = apply_go && do_remove_idx && (CW'(k) >= idx);
      assign ctrl[k].from_right_found = apply_go && do_remove_found;
      assign ctrl[k].capture          = (state_ff == bole_pkg::FSM_MATCH);

      bole_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl[k]),
         .valid       (CW'(k) < count_ff),
         .key         (key_ff),
         .new_value   (key_ff),
         .left_value  (cell_value[(k == 0) ? 0 : k - 1]),
         .right_value (cell_value[(k == CAPACITY - 1) ? k : k + 1]),
         .found_in    (found[k]),
         .value       (cell_value[k]),
         .found_out   (found[k + 1])
      );
   end

   // Control registers.
   assign rsp_valid_in = apply_go ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bole_pkg::FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (apply_go) begin
            count_ff <= count_in;
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (apply_go) begin
         rsp_status_ff <= status_in;
         rsp_length_ff <= count_in_ext[4:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_length_ff, rsp_status_ff};

   // The entry count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // An accepted request moves straight into the compare step.
   a_accept_to_match: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == bole_pkg::FSM_MATCH))
      else $error("accepted request did not enter compare");

   // A pending full status means the list is still at capacity.
   a_full_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == bole_pkg::STAT_FULL) |-> (count_ff == CW'(CAPACITY)))
      else $error("full status with room left");

   // The length moves by at most one per request.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      apply_go |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + CW'(1)
                    || count_ff == $past(count_ff) - CW'(1)))
      else $error("length changed by more than one");

   // The count only changes while a response is produced.
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != bole_pkg::FSM_APPLY) |=> $stable(count_ff))
      else $error("count changed outside the apply step");

endmodule

@@ tb/sv/bounded_ordered_list_engine_tb.sv @@
`timescale 1ns / 100ps

module bounded_ordered_list_engine_tb;

   localparam int LIST_CAPACITY = 16;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 400;

   // Request codes that the block does not implement.
   localparam logic [2:0] REQ_UNUSED_A = 3'd6;
   localparam logic [2:0] REQ_UNUSED_B = 3'd7;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] length;
   } outcome_type;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] value;
      logic [4:0]  pos;
      int          reps;
      bit          typed;
      logic [2:0]  status;
      logic [4:0]  length;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // req_type[2:0], data_value[34:3], position[39:35]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // status[2:0], list_length[7:3]

   // Shadow copy of the list kept by the predictor.
   logic [31:0] list_entries [LIST_CAPACITY];
   int          list_count = 0;

   outcome_type pending_outcomes [$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          stall_left = 0;

   // Directed requests; rows with typed set carry an expectation read off by hand.
   stim_row_type directed_rows [21] = '{
      '{bole_pkg::REQ_REM_BACK,  32'h0000_0000, 5'd0,  1,  1'b1, bole_pkg::STAT_EMPTY,    5'd0},
      '{bole_pkg::REQ_REM_FRONT, 32'h0000_0000, 5'd0,  1,  1'b1, bole_pkg::STAT_EMPTY,    5'd0},
      '{bole_pkg::REQ_REM_VALUE, 32'h0000_0000, 5'd0,  1,  1'b1, bole_pkg::STAT_EMPTY,    5'd0},
      '{bole_pkg::REQ_INS_AFTER, 32'h0000_0005, 5'd0,  1,  1'b1, bole_pkg::STAT_BEYOND,   5'd0},
      '{REQ_UNUSED_A,            32'hFFFF_FFFF, 5'd31, 1,  1'b1, bole_pkg::STAT_OK,       5'd0},
      '{bole_pkg::REQ_INS_FRONT, 32'h8000_0000, 5'd0,  1,  1'b1, bole_pkg::STAT_OK,       5'd1},
      '{bole_pkg::REQ_INS_BACK,  32'h7FFF_FFFF, 5'd31, 1,  1'b1, bole_pkg::STAT_OK,       5'd2},
      '{bole_pkg::REQ_INS_AFTER, 32'hFFFF_FFFF, 5'd0,  1,  1'b1, bole_pkg::STAT_OK,       5'd3},
      '{bole_pkg::REQ_INS_AFTER, 32'h0000_0001, 5'd31, 1,  1'b1, bole_pkg::STAT_BEYOND,   5'd3},
      '{bole_pkg::REQ_INS_AFTER, 32'h0000_0000, 5'd3,  1,  1'b0, bole_pkg::STAT_OK,       5'd0},
      '{bole_pkg::REQ_REM_VALUE, 32'h0000_3039, 5'd0,  1,  1'b1, bole_pkg::STAT_NOTFOUND, 5'd4},
      '{bole_pkg::REQ_REM_VALUE, 32'h7FFF_FFFF, 5'd0,  1,  1'b0, bole_pkg::STAT_OK,       5'd0},
      '{REQ_UNUSED_B,            32'hFFFF_FFFF, 5'd31, 1,  1'b1, bole_pkg::STAT_OK,       5'd3},
      '{bole_pkg::REQ_REM_FRONT, 32'h0000_0000, 5'd0,  1,  1'b0, bole_pkg::STAT_OK,       5'd0},
      '{bole_pkg::REQ_REM_BACK,  32'h0000_0000, 5'd0,  1,  1'b0, bole_pkg::STAT_OK,       5'd0},
      '{bole_pkg::REQ_INS_BACK,  32'h55AA_55AA, 5'd0,  15, 1'b0, bole_pkg::STAT_OK,       5'd0},
      '{bole_pkg::REQ_INS_FRONT, 32'h0000_0000, 5'd0,  1,  1'b1, bole_pkg::STAT_FULL,     5'd16},
      '{bole_pkg::REQ_INS_BACK,  32'hFFFF_FFFF, 5'd0,  1,  1'b1, bole_pkg::STAT_FULL,     5'd16},
      '{bole_pkg::REQ_INS_AFTER, 32'h0000_0000, 5'd31, 1,  1'b1, bole_pkg::STAT_FULL,     5'd16},
      '{bole_pkg::REQ_REM_VALUE, 32'h55AA_55B1, 5'd0,  1,  1'b0, bole_pkg::STAT_OK,       5'd0},
      '{bole_pkg::REQ_INS_AFTER, 32'hA5A5_A5A5, 5'd15, 1,  1'b0, bole_pkg::STAT_OK,       5'd0}
   };

   bounded_ordered_list_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one request to the shadow list and return its status and new length.
   function automatic outcome_type apply_request(logic [2:0] kind, logic [31:0] value,
                                                 logic [4:0] pos);
      outcome_type result;
      int          slot;
      int          where;
      logic [4:0]  after;
      result.status = bole_pkg::STAT_OK;
      slot = -1;
      where = -1;
      after = (pos == 5'd0) ? 5'd1 : pos;
      case (kind)
         bole_pkg::REQ_INS_FRONT, bole_pkg::REQ_INS_BACK, bole_pkg::REQ_INS_AFTER: begin
            if (list_count >= LIST_CAPACITY) begin
               result.status = bole_pkg::STAT_FULL;
            end else if (kind == bole_pkg::REQ_INS_FRONT) begin
               slot = 0;
            end else if (kind == bole_pkg::REQ_INS_BACK) begin
               slot = list_count;
            end else if (list_count == 0 || int'(after) > list_count) begin
               result.status = bole_pkg::STAT_BEYOND;
            end else begin
               slot = int'(after);
            end
         end
         bole_pkg::REQ_REM_BACK: begin
            if (list_count == 0) result.status = bole_pkg::STAT_EMPTY;
            else where = list_count - 1;
         end
         bole_pkg::REQ_REM_FRONT: begin
            if (list_count == 0) result.status = bole_pkg::STAT_EMPTY;
            else where = 0;
         end
         bole_pkg::REQ_REM_VALUE: begin
            if (list_count == 0) begin
               result.status = bole_pkg::STAT_EMPTY;
            end else begin
               result.status = bole_pkg::STAT_NOTFOUND;
               for (int k = 0; k < list_count; k++) begin
                  if (where < 0 && list_entries[k] == value) where = k;
               end
               if (where >= 0) result.status = bole_pkg::STAT_OK;
            end
         end
         default: begin
         end
      endcase
      // Open a gap for an insert, or close one for a removal.
      if (slot >= 0) begin
         for (int k = list_count; k > slot; k--) list_entries[k] = list_entries[k - 1];
         list_entries[slot] = value;
         list_count++;
      end
      if (where >= 0) begin
         for (int k = where; k + 1 < list_count; k++) list_entries[k] = list_entries[k + 1];
         list_count--;
      end
      result.length = list_count[4:0];
      return result;
   endfunction

   // Drive one request in bursts with random gaps, then record its expected outcome.
   task automatic send_request(input logic [2:0] kind, input logic [31:0] value,
                               input logic [4:0] pos, input bit typed,
                               input outcome_type typed_outcome);
      int          gap;
      outcome_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(24, 1);
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {pos, value, kind};
      do @(posedge clock); while (!req_tready);
      predicted = apply_request(kind, value, pos);
      pending_outcomes.push_back(typed ? typed_outcome : predicted);
   endtask

   // Stimulus: directed table first, then random requests that sweep the length.
   initial begin
      int          ins_weight;
      int          r;
      logic [2:0]  kind;
      logic [31:0] value;
      logic [4:0]  pos;
      outcome_type row_outcome;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row_outcome.status = directed_rows[i].status;
         row_outcome.length = directed_rows[i].length;
         for (int j = 0; j < directed_rows[i].reps; j++) begin
            send_request(directed_rows[i].kind, directed_rows[i].value + 32'(j),
                         directed_rows[i].pos, directed_rows[i].typed, row_outcome);
         end
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Phases alternate between draining, balanced and filling the list.
         case ((n / 40) % 3)
            0: ins_weight = 27;
            1: ins_weight = 48;
            default: ins_weight = 70;
         endcase
         r = $urandom_range(99);
         if (r < 3) begin
            kind = ($urandom_range(1) == 0) ? REQ_UNUSED_A : REQ_UNUSED_B;
         end else if (r < 3 + ins_weight) begin
            case ($urandom_range(2))
               0: kind = bole_pkg::REQ_INS_FRONT;
               1: kind = bole_pkg::REQ_INS_BACK;
               default: kind = bole_pkg::REQ_INS_AFTER;
            endcase
         end else begin
            case ($urandom_range(2))
               0: kind = bole_pkg::REQ_REM_BACK;
               1: kind = bole_pkg::REQ_REM_FRONT;
               default: kind = bole_pkg::REQ_REM_VALUE;
            endcase
         end

         // Values often repeat or come from the list so that searches hit.
         r = $urandom_range(9);
         if (r < 4 && list_count > 0) value = list_entries[$urandom_range(list_count - 1)];
         else if (r < 7) value = $urandom_range(3);
         else value = $urandom;

         // Positions mostly fall near the current length.
         if ($urandom_range(9) < 7) pos = 5'($urandom_range(list_count + 1));
         else pos = 5'($urandom_range(31));

         send_request(kind, value, pos, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("bounded_ordered_list_engine_tb OK");
      end else begin
         $display("bounded_ordered_list_engine_tb NOT OK");
      end
      $finish;
   end

   // Response stalls: quiet, light and heavy stretches in turn.
   always @(posedge clock) begin
      int odds;
      case ((cycle_count / 64) % 3)
         0: odds = 0;
         1: odds = 4;
         default: odds = 2;
      endcase
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (odds > 0 && $urandom_range(odds - 1) == 0) stall_left <= $urandom_range(8, 1);
      end
   end

   // Compare every accepted response with the oldest expected outcome.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response with no request outstanding: status %0d, list_length %0d",
                   rsp_tdata[2:0], rsp_tdata[7:3]);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_tdata[2:0] !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tdata[2:0]);
               error_count++;
            end
            if (rsp_tdata[7:3] !== want.length) begin
               $error("list_length: expected %0d, actual %0d", want.length, rsp_tdata[7:3]);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bounded_ordered_list_engine_tb NOT OK");
         $finish;
      end
   end

endmodule
